// ===== src/touch_contact_release_debouncer_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TOUCH_CONTACT_RELEASE_DEBOUNCER_TOP_ASSERT_SVH
`define TOUCH_CONTACT_RELEASE_DEBOUNCER_TOP_ASSERT_SVH

// same-cycle implication
`define TCRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcrd_pkg.sv =====
package tcrd_pkg;

  localparam int NUM_POINTERS_DEF = 2;

  localparam logic [7:0] SLOW_RATE_THRESHOLD  = 8'd20;
  localparam logic [7:0] LONG_TOUCH_THRESHOLD = 8'd100;
  localparam logic [7:0] SAMPLES_MAX          = 8'hFF;

  localparam logic [1:0]  QUIRK_RESET         = 2'd0;
  localparam logic [15:0] SHORT_TICKS_RESET   = 16'd100;
  localparam logic [15:0] LONG_TICKS_RESET    = 16'd500;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam int QUIRK_SLOW_RATE   = 0;
  localparam int QUIRK_RELEASE_WA  = 1;

  // configuration register indexes
  localparam logic [1:0] CFG_QUIRK   = 2'd0;
  localparam logic [1:0] CFG_SHORT   = 2'd1;
  localparam logic [1:0] CFG_LONG    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  typedef enum logic [1:0] {
    EV_UPDATE  = 2'd0,
    EV_RELEASE = 2'd1,
    EV_TIMEOUT = 2'd2
  } event_kind_t;

  typedef enum logic [4:0] {
    PH_WAITING    = 5'b00001,
    PH_READING    = 5'b00010,
    PH_RELEASING  = 5'b00100,
    PH_DEBOUNCING = 5'b01000,
    PH_RECOVERING = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  pointer_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        touching;
    logic        confident;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  out_pointer;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        touch_major;
    logic        last_event;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  quirk;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic emit_a;
    logic emit_b;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] res_cnt;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic        expire;
    logic        rpt_emit;
    logic [1:0]  rpt_kind;
    logic        rpt_touch;
    logic [15:0] held_x;
    logic [15:0] held_y;
  } lane_out_t;

  function automatic logic [15:0] pick_debounce(input logic [7:0] n, input cfg_t cfg);
    logic use_long;
    use_long = ((n > SLOW_RATE_THRESHOLD) && cfg.quirk[QUIRK_SLOW_RATE]) ||
               (n > LONG_TOUCH_THRESHOLD);
    return use_long ? cfg.long_ticks : cfg.short_ticks;
  endfunction

endpackage

// ===== src/tcrd_lane.sv =====
module tcrd_lane (
  input  logic               clk,
  input  logic               rst,
  input  tcrd_pkg::cfg_t     cfg,
  input  logic               rpt_en,
  input  logic               tick_en,
  input  logic               grant,
  input  logic [15:0]        pos_x,
  input  logic [15:0]        pos_y,
  input  logic               touching,
  output tcrd_pkg::lane_out_t lane_out
);
  import tcrd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] held_x, held_x_next;
  logic [15:0] held_y, held_y_next;
  logic [7:0]  samples, samples_next;
  logic [15:0] remaining, remaining_next;
  logic        running, running_next;
  logic [7:0]  samp_new;
  logic        emit;
  logic [1:0]  kind;
  logic        tch;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAITING;
      held_x    <= '0;
      held_y    <= '0;
      samples   <= '0;
      remaining <= '0;
      running   <= 1'b0;
    end else begin
      phase     <= phase_next;
      held_x    <= held_x_next;
      held_y    <= held_y_next;
      samples   <= samples_next;
      remaining <= remaining_next;
      running   <= running_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    held_x_next    = held_x;
    held_y_next    = held_y;
    samples_next   = samples;
    remaining_next = remaining;
    running_next   = running;
    samp_new       = (phase == PH_WAITING) ? 8'd1 :
                     (samples == SAMPLES_MAX) ? samples : samples + 8'd1;
    emit           = 1'b0;
    kind           = EV_UPDATE;
    tch            = 1'b0;
    if (rpt_en) begin
      held_x_next = pos_x;
      held_y_next = pos_y;
      unique case (phase) inside
        PH_WAITING, PH_READING: begin
          samples_next = samp_new;
          emit         = 1'b1;
          if (touching) begin
            kind        = EV_UPDATE;
            tch         = 1'b1;
            phase_next  = PH_READING;
            if (cfg.quirk[QUIRK_RELEASE_WA]) begin
              remaining_next = cfg.timeout_ticks;
              running_next   = 1'b1;
            end
          end else begin
            kind           = EV_RELEASE;
            tch            = touching;
            phase_next     = PH_DEBOUNCING;
            remaining_next = pick_debounce(samp_new, cfg);
            running_next   = 1'b1;
          end
        end
        PH_RELEASING: begin
          emit           = 1'b1;
          kind           = EV_RELEASE;
          tch            = touching;
          phase_next     = PH_DEBOUNCING;
          remaining_next = pick_debounce(samples, cfg);
          running_next   = 1'b1;
        end
        PH_DEBOUNCING: begin
        end
        PH_RECOVERING: begin
          if (touching) phase_next = PH_WAITING;
        end
        default: phase_next = PH_WAITING;
      endcase
    end else if (tick_en && running) begin
      if (remaining > 16'd1) begin
        remaining_next = remaining - 16'd1;
      end else begin
        unique case (phase)
          PH_READING: begin
            // hold one tick left when both result slots of this tick are taken
            if (grant) begin
              phase_next     = PH_RECOVERING;
              running_next   = 1'b0;
              remaining_next = '0;
            end else begin
              remaining_next = 16'd1;
            end
          end
          PH_DEBOUNCING: begin
            phase_next     = PH_WAITING;
            running_next   = 1'b0;
            remaining_next = '0;
          end
          default: begin
            running_next   = 1'b0;
            remaining_next = '0;
          end
        endcase
      end
    end
  end

  assign lane_out.expire    = running && (remaining <= 16'd1) && (phase == PH_READING);
  assign lane_out.rpt_emit  = emit;
  assign lane_out.rpt_kind  = kind;
  assign lane_out.rpt_touch = tch;
  assign lane_out.held_x    = held_x;
  assign lane_out.held_y    = held_y;

endmodule

// ===== src/tcrd_datapath.sv =====
module tcrd_datapath #(
  parameter int NUM_POINTERS = tcrd_pkg::NUM_POINTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tcrd_pkg::dp_cmd_t   cmd,
  output tcrd_pkg::dp_stat_t  stat,
  input  tcrd_pkg::in_word_t  item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                result_valid,
  input  logic                result_ready,
  output tcrd_pkg::out_word_t result
);
  import tcrd_pkg::*;

  localparam int IDX_W = (NUM_POINTERS > 1) ? $clog2(NUM_POINTERS) : 1;

  cfg_t       cfg;
  in_word_t   in_reg;
  logic [1:0] res_cnt;
  logic [IDX_W-1:0] idx_a, idx_b, sel;
  logic [1:0] kind_a;
  logic       touch_a;
  logic       out_free;

  lane_out_t lane_out [NUM_POINTERS];
  logic [NUM_POINTERS-1:0] hit, expire_mask, mask2;
  logic       has_first, has_second;
  logic [IDX_W-1:0] first, second;
  logic       rpt_any, rpt_touch;
  logic [1:0] rpt_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quirk         <= QUIRK_RESET;
      cfg.short_ticks   <= SHORT_TICKS_RESET;
      cfg.long_ticks    <= LONG_TICKS_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUIRK:   cfg.quirk         <= cfg_data[1:0];
        CFG_SHORT:   cfg.short_ticks   <= cfg_data;
        CFG_LONG:    cfg.long_ticks    <= cfg_data;
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_POINTERS; g++) begin : g_lane
    assign hit[g] = (in_reg.pointer_id == 8'(g));
    assign expire_mask[g] = lane_out[g].expire;
    tcrd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .rpt_en   (cmd.exec && !in_reg.mode && in_reg.confident && hit[g]),
      .tick_en  (cmd.exec && in_reg.mode),
      .grant    ((has_first && (first == IDX_W'(g))) ||
                 (has_second && (second == IDX_W'(g)))),
      .pos_x    (in_reg.pos_x),
      .pos_y    (in_reg.pos_y),
      .touching (in_reg.touching),
      .lane_out (lane_out[g])
    );
  end

  // lowest two expiring timeouts take this tick's result slots
  always_comb begin
    has_first  = 1'b0;
    first      = '0;
    has_second = 1'b0;
    second     = '0;
    for (int i = NUM_POINTERS - 1; i >= 0; i--) begin
      if (expire_mask[i]) begin
        has_first = 1'b1;
        first     = IDX_W'(i);
      end
    end
    for (int i = 0; i < NUM_POINTERS; i++) begin
      mask2[i] = expire_mask[i] && !(has_first && (first == IDX_W'(i)));
    end
    for (int i = NUM_POINTERS - 1; i >= 0; i--) begin
      if (mask2[i]) begin
        has_second = 1'b1;
        second     = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rpt_any   = 1'b0;
    rpt_kind  = '0;
    rpt_touch = 1'b0;
    for (int i = 0; i < NUM_POINTERS; i++) begin
      rpt_any   = rpt_any | lane_out[i].rpt_emit;
      rpt_kind  = rpt_kind | (lane_out[i].rpt_emit ? lane_out[i].rpt_kind : 2'd0);
      rpt_touch = rpt_touch | (lane_out[i].rpt_emit & lane_out[i].rpt_touch);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_reg <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (cmd.exec) begin
      if (in_reg.mode) begin
        res_cnt <= {1'b0, has_first} + {1'b0, has_second};
      end else begin
        res_cnt <= {1'b0, rpt_any};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (in_reg.mode) begin
        idx_a   <= first;
        idx_b   <= second;
        kind_a  <= EV_TIMEOUT;
        touch_a <= 1'b0;
      end else begin
        idx_a   <= in_reg.pointer_id[IDX_W-1:0];
        idx_b   <= second;
        kind_a  <= rpt_kind;
        touch_a <= rpt_touch;
      end
    end
  end

  assign out_free = !result_valid || result_ready;
  assign sel      = cmd.emit_b ? idx_b : idx_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_a || cmd.emit_b) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_a || cmd.emit_b) begin
      result.event_kind  <= cmd.emit_b ? EV_TIMEOUT : kind_a;
      result.out_pointer <= 4'(sel);
      result.out_x       <= lane_out[sel].held_x;
      result.out_y       <= lane_out[sel].held_y;
      result.touch_major <= cmd.emit_b ? 1'b0 : touch_a;
      result.last_event  <= cmd.emit_b || (res_cnt == 2'd1);
    end
  end

  assign stat.res_cnt  = res_cnt;
  assign stat.out_free = out_free;

endmodule

// ===== src/tcrd_ctrl.sv =====
module tcrd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  tcrd_pkg::dp_stat_t stat,
  output tcrd_pkg::dp_cmd_t  cmd
);
  import tcrd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_EMIT_A = 4'b0100,
    S_EMIT_B = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (stat.res_cnt == 2'd0) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_a = 1'b1;
          state_next = (stat.res_cnt == 2'd2) ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (stat.out_free) begin
          cmd.emit_b = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/touch_contact_release_debouncer_top.sv =====
// channel   direction  handshake                  word
// item      in         item_valid / item_ready    tcrd_pkg::in_word_t
// result    out        result_valid / result_ready tcrd_pkg::out_word_t
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// An item passes through accept, execute and first word out, plus an emit step for a second
// result word; the single output register and the controller's walk over it set this.
// A tick updates all pointer timers together in the execute state. rst is synchronous;
// lane state, cfg, res_cnt and result_valid reset, but in_reg, idx and result do not.
// A stalled result holds the controller until the output register frees up.
module touch_contact_release_debouncer_top #(
  parameter int NUM_POINTERS = tcrd_pkg::NUM_POINTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tcrd_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output tcrd_pkg::out_word_t result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import tcrd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcrd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcrd_datapath #(
    .NUM_POINTERS (NUM_POINTERS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== src/tcrd_checker.sv =====
`include "touch_contact_release_debouncer_top_assert.svh"

module tcrd_checker #(
  parameter int NUM_POINTERS = tcrd_pkg::NUM_POINTERS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input tcrd_pkg::out_word_t result
);
  import tcrd_pkg::*;

  `TCRD_ASSERT_IMP(a_kind_legal, result_valid,
    (result.event_kind == EV_UPDATE) || (result.event_kind == EV_RELEASE) ||
    (result.event_kind == EV_TIMEOUT), "illegal event kind")

  `TCRD_ASSERT_IMP(a_timeout_word, result_valid && (result.event_kind == EV_TIMEOUT),
    !result.touch_major && (result.out_pointer < NUM_POINTERS), "bad timeout word")

  `TCRD_ASSERT_NXT(a_one_at_a_time, item_valid && item_ready, !item_ready,
    "new word taken while one is in work")

  `TCRD_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result), "stalled result word changed")

endmodule

bind touch_contact_release_debouncer_top tcrd_checker #(
  .NUM_POINTERS (NUM_POINTERS)
) u_tcrd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrd_pkg::*;

  localparam int NPTR          = NUM_POINTERS_DEF;
  localparam int MAX_EVENTS    = 2;
  localparam logic [7:0] SLOW_TOUCH_MIN = 8'd20;
  localparam logic [7:0] LONG_TOUCH_MIN = 8'd100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_WORDS   = 70;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_style_t;

  class contact_tracker;
    logic [1:0]  quirk;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] timeout_ticks;
    phase_t      stage[NPTR];
    logic [15:0] held_x[NPTR];
    logic [15:0] held_y[NPTR];
    logic [7:0]  seen[NPTR];
    logic [15:0] remaining[NPTR];
    logic        armed[NPTR];
    out_word_t   due_events[$];
    int          errors;

    function new();
      quirk = 2'd0;
      short_ticks = 16'd100;
      long_ticks = 16'd500;
      timeout_ticks = 16'd1000;
      errors = 0;
      for (int i = 0; i < NPTR; i++) begin
        stage[i] = PH_WAITING;
        held_x[i] = '0;
        held_y[i] = '0;
        seen[i] = '0;
        remaining[i] = '0;
        armed[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_QUIRK:   quirk = val[1:0];
        CFG_SHORT:   short_ticks = val;
        CFG_LONG:    long_ticks = val;
        CFG_TIMEOUT: timeout_ticks = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] debounce_len(logic [7:0] n);
      if ((n > SLOW_TOUCH_MIN && quirk[QUIRK_SLOW_RATE]) || n > LONG_TOUCH_MIN)
        return long_ticks;
      return short_ticks;
    endfunction

    function out_word_t make_event(event_kind_t kind, int p, logic touch);
      out_word_t ev;
      ev.event_kind = kind;
      ev.out_pointer = p[3:0];
      ev.out_x = held_x[p];
      ev.out_y = held_y[p];
      ev.touch_major = touch;
      ev.last_event = 1'b0;
      return ev;
    endfunction

    function void apply_word(in_word_t w);
      out_word_t evs[$];
      int p;
      if (w.mode) begin
        for (int i = 0; i < NPTR; i++) begin
          if (!armed[i]) continue;
          if (remaining[i] > 16'd1) begin
            remaining[i]--;
            continue;
          end
          if (stage[i] == PH_READING) begin
            // hold a third expiry for the next tick
            if (evs.size() >= MAX_EVENTS) begin
              remaining[i] = 16'd1;
              continue;
            end
            evs.push_back(make_event(EV_TIMEOUT, i, 1'b0));
            stage[i] = PH_RECOVERING;
          end else if (stage[i] == PH_DEBOUNCING) begin
            stage[i] = PH_WAITING;
          end
          armed[i] = 1'b0;
          remaining[i] = '0;
        end
      end else if (w.confident && w.pointer_id < NPTR) begin
        p = int'(w.pointer_id);
        held_x[p] = w.pos_x;
        held_y[p] = w.pos_y;
        if (stage[p] == PH_WAITING) begin
          seen[p] = '0;
          stage[p] = PH_READING;
        end
        case (stage[p])
          PH_READING: begin
            if (seen[p] != 8'hFF) seen[p]++;
            if (w.touching) begin
              evs.push_back(make_event(EV_UPDATE, p, 1'b1));
              if (quirk[QUIRK_RELEASE_WA]) begin
                remaining[p] = timeout_ticks;
                armed[p] = 1'b1;
              end
            end else begin
              evs.push_back(make_event(EV_RELEASE, p, w.touching));
              stage[p] = PH_DEBOUNCING;
              remaining[p] = debounce_len(seen[p]);
              armed[p] = 1'b1;
            end
          end
          PH_RECOVERING: begin
            if (w.touching) stage[p] = PH_WAITING;
          end
          default: ;
        endcase
      end
      if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
      foreach (evs[k]) due_events.push_back(evs[k]);
    endfunction

    function void match_event(out_word_t got);
      out_word_t want;
      if (due_events.size() == 0) begin
        $error("result word %h with none expected", got);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
        errors++;
      end
      if (got.out_pointer !== want.out_pointer) begin
        $error("out_pointer: expected %0d, got %0d", want.out_pointer, got.out_pointer);
        errors++;
      end
      if (got.out_x !== want.out_x) begin
        $error("out_x: expected %h, got %h", want.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y: expected %h, got %h", want.out_y, got.out_y);
        errors++;
      end
      if (got.touch_major !== want.touch_major) begin
        $error("touch_major: expected %b, got %b", want.touch_major, got.touch_major);
        errors++;
      end
      if (got.last_event !== want.last_event) begin
        $error("last_event: expected %b, got %b", want.last_event, got.last_event);
        errors++;
      end
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  in_word_t    item;
  logic        result_valid;
  logic        result_ready;
  out_word_t   result;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  contact_tracker tracker;
  bit long_hold_req = 1'b0;
  int burst_left = 0;
  int live_words = 0;
  int cycles = 0;

  touch_contact_release_debouncer_top #(
    .NUM_POINTERS(NPTR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("touch_contact_release_debouncer_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) tracker.apply_word(item);
    if (!rst && result_valid && result_ready) tracker.match_event(result);
  end

  initial begin : result_sink
    int seg_left;
    int tick_cnt;
    sink_style_t style;
    result_ready = 1'b0;
    seg_left = 0;
    tick_cnt = 0;
    style = SINK_OPEN;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // hold off long enough for the block to back up into its input
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 96);
          style = sink_style_t'($urandom_range(0, 3));
        end
        seg_left--;
        tick_cnt++;
        case (style)
          SINK_OPEN:   result_ready <= 1'b1;
          SINK_COIN:   result_ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: result_ready <= ($urandom_range(0, 4) == 0);
          default:     result_ready <= (tick_cnt % 4 == 0);
        endcase
      end
    end
  end

  function automatic in_word_t contact(input logic [7:0] id, input logic [15:0] x, y,
                                       input logic t, c);
    in_word_t w;
    w.mode = 1'b0;
    w.pointer_id = id;
    w.pos_x = x;
    w.pos_y = y;
    w.touching = t;
    w.confident = c;
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = contact(8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    w.mode = 1'b1;
    return w;
  endfunction

  function automatic in_word_t noise_word(input bit touch_only);
    logic t;
    t = touch_only ? 1'b1 : 1'($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: return tick_word();
      1: return contact(8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
      2: return contact(8'($urandom_range(NPTR, 255)), 16'($urandom), 16'($urandom),
                        1'($urandom), 1'b1);
      default: return contact(8'($urandom_range(0, NPTR - 1)), 16'($urandom),
                              16'($urandom), t, 1'b1);
    endcase
  endfunction

  // drive one word; the sender runs in bursts with gaps in between
  task automatic offer(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    if (w.mode || (w.confident && w.pointer_id < NPTR)) live_words++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    tracker.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [1:0] q, input logic [15:0] s, l, t);
    write_reg(CFG_QUIRK, {14'd0, q});
    write_reg(CFG_SHORT, s);
    write_reg(CFG_LONG, l);
    write_reg(CFG_TIMEOUT, t);
    cfg_we <= 1'b0;
  endtask

  // touch runs on one pointer with noise mixed in, then usually a lift, and some ticks
  task automatic play(input int quota, input bit long_run, input bit touch_only);
    int start;
    int p;
    int len;
    int pick;
    bit first;
    bit calm;
    start = live_words;
    first = long_run;
    while (live_words - start < quota) begin
      p = $urandom_range(0, NPTR - 1);
      pick = $urandom_range(0, 9);
      if (first) len = $urandom_range(256, 270);
      else if (pick < 7) len = $urandom_range(1, 6);
      else if (pick < 9) len = $urandom_range(15, 30);
      else len = $urandom_range(95, 115);
      // keep the long run free of noise so the count reaches its ceiling
      calm = first;
      first = 1'b0;
      repeat (len) begin
        if (!calm && $urandom_range(0, 7) == 0) offer(noise_word(touch_only));
        offer(contact(8'(p), 16'($urandom), 16'($urandom), 1'b1, 1'b1));
      end
      if (!touch_only && $urandom_range(0, 9) != 0)
        offer(contact(8'(p), 16'($urandom), 16'($urandom), 1'b0, 1'b1));
      repeat ($urandom_range(0, 8)) offer(tick_word());
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: field extremes and dropped reports
    offer(contact(8'd0, 16'h0000, 16'h0000, 1'b1, 1'b1));
    offer(contact(8'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    offer(contact(8'd0, 16'h1234, 16'h4321, 1'b1, 1'b0));
    offer(contact(8'd2, 16'h5555, 16'hAAAA, 1'b1, 1'b1));
    offer(contact(8'hFF, 16'hAAAA, 16'h5555, 1'b1, 1'b1));
    offer('1);
    offer(contact(8'd1, 16'hA5A5, 16'h5A5A, 1'b1, 1'b1));
    settle();

    // timeouts on both pointers in one tick, recovery, debounce expiry
    load_settings(2'd2, 16'd1, 16'd2, 16'd1);
    offer(contact(8'd0, 16'h0F0F, 16'hF0F0, 1'b1, 1'b1));
    offer(contact(8'd1, 16'h00FF, 16'hFF00, 1'b1, 1'b1));
    offer(tick_word());
    offer(contact(8'd0, 16'h1111, 16'h2222, 1'b0, 1'b1));
    offer(contact(8'd0, 16'h3333, 16'h4444, 1'b1, 1'b1));
    offer(contact(8'd1, 16'h5555, 16'h6666, 1'b1, 1'b1));
    offer(contact(8'd0, 16'h7777, 16'h8888, 1'b1, 1'b1));
    offer(contact(8'd0, 16'h9999, 16'hAAAA, 1'b0, 1'b1));
    offer(contact(8'd0, 16'hBBBB, 16'hCCCC, 1'b1, 1'b1));
    offer(tick_word());
    settle();

    // zero-length timers expire on the next tick
    load_settings(2'd3, 16'd0, 16'd0, 16'd0);
    offer(contact(8'd1, 16'hDEAD, 16'hBEEF, 1'b1, 1'b1));
    offer(tick_word());
    offer(contact(8'd1, 16'hCAFE, 16'hF00D, 1'b1, 1'b1));
    offer(contact(8'd0, 16'h0001, 16'h8000, 1'b0, 1'b1));
    offer(tick_word());
    settle();

    load_settings(2'd3, 16'd3, 16'd7, 16'd6);
    long_hold_req = 1'b1;
    play(PHASE_WORDS, 1'b0, 1'b0);
    settle();

    // minimum lengths, plus one touch long enough to saturate the count
    load_settings(2'd0, 16'd1, 16'd2, 16'd1);
    play(PHASE_WORDS, 1'b1, 1'b0);
    settle();

    // maximum lengths: no lifts, or a pointer would sit in debounce for good
    load_settings(2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    play(PHASE_WORDS, 1'b0, 1'b1);
    settle();

    load_settings(2'd1, 16'd4, 16'd2, 16'd9);
    play(PHASE_WORDS, 1'b0, 1'b0);
    settle();

    load_settings(2'd2, 16'd2, 16'd5, 16'd1);
    play(PHASE_WORDS, 1'b0, 1'b0);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("touch_contact_release_debouncer_top test passed");
    end else begin
      $display("touch_contact_release_debouncer_top test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tcrd_pkg.sv
src/tcrd_lane.sv
src/tcrd_datapath.sv
src/tcrd_ctrl.sv
src/touch_contact_release_debouncer_top.sv
src/tcrd_checker.sv
bench/tb.sv
